[design/yags_pkg.sv]
// shared types, constants and a helper function for the yags branch predictor
package yags_pkg;

    // default geometry
    localparam int CHOICE_INDEX_BITS_DEF    = 12;
    localparam int EXCEPTION_INDEX_BITS_DEF = 10;
    localparam int TAG_WIDTH_DEF            = 8;
    localparam int PC_SHIFT_DEF             = 2;

    // fixed field widths on the ports
    localparam int PC_BITS      = 64;
    localparam int HIST_BITS    = 10;
    localparam int IN_DATA_BITS = 80;
    localparam int OUT_DATA_BITS = 8;

    // result buffer depth
    localparam int OUT_DEPTH    = 3;
    localparam int OUT_PTR_BITS = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_BITS = $clog2(OUT_DEPTH + 1);

    typedef logic [1:0] ctr_t;

    // item kinds
    localparam logic MODE_PREDICT = 1'b0;
    localparam logic MODE_UPDATE  = 1'b1;

    // two-bit counter values
    localparam ctr_t CTR_STRONG_NT = 2'd0;
    localparam ctr_t CTR_WEAK_NT   = 2'd1;
    localparam ctr_t CTR_WEAK_T    = 2'd2;
    localparam ctr_t CTR_STRONG_T  = 2'd3;

    localparam ctr_t STEP_UP   [4] = '{2'd1, 2'd2, 2'd3, 2'd3};
    localparam ctr_t STEP_DOWN [4] = '{2'd0, 2'd0, 2'd1, 2'd2};

    // control from the update logic to the memories and the result buffer
    typedef struct packed {
        logic choice_we;
        logic exc_we;
        logic push;
        logic pred;
    } yags_ctl_t;

    function automatic ctr_t sat_step(input ctr_t c, input logic up);
        ctr_t r;
        if (up)
        begin
            r = STEP_UP[c];
        end
        else
        begin
            r = STEP_DOWN[c];
        end
        return r;
    endfunction

endpackage

[design/yags_ram.sv]
// simple dual-port synchronous ram, one write and one registered read port
module yags_ram #(
    parameter int ADDR_BITS = 10,
    parameter int DATA_BITS = 8
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [DATA_BITS-1:0] wdata,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [DATA_BITS-1:0] rdata
);

    logic [DATA_BITS-1:0] mem [2**ADDR_BITS];
    logic [DATA_BITS-1:0] rdata_reg;

    // read returns old data on a same-address write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[design/yags_calc.sv]
// prediction and counter / exception update from one read of the tables
module yags_calc #(
    parameter int TAG_WIDTH = yags_pkg::TAG_WIDTH_DEF
) (
    input  logic                      item_valid,
    input  logic                      mode,
    input  logic                      taken,
    input  logic [TAG_WIDTH-1:0]      tag,
    input  yags_pkg::ctr_t            choice_rd,
    input  logic [2*TAG_WIDTH+3:0]    exc_rd,
    output yags_pkg::ctr_t            choice_wd,
    output logic [2*TAG_WIDTH+3:0]    exc_wd,
    output yags_pkg::yags_ctl_t       ctl
);

    // exception word: {nt_tag, nt_ctr, t_tag, t_ctr}
    logic [TAG_WIDTH-1:0] t_tag;
    logic [TAG_WIDTH-1:0] nt_tag;
    yags_pkg::ctr_t       t_ctr;
    yags_pkg::ctr_t       nt_ctr;
    logic [TAG_WIDTH-1:0] t_tag_wd;
    logic [TAG_WIDTH-1:0] nt_tag_wd;
    yags_pkg::ctr_t       t_ctr_wd;
    yags_pkg::ctr_t       nt_ctr_wd;
    logic                 bias;
    logic                 t_hit;
    logic                 nt_hit;
    logic                 is_update;

    assign t_ctr  = exc_rd[1:0];
    assign t_tag  = exc_rd[TAG_WIDTH+1:2];
    assign nt_ctr = exc_rd[TAG_WIDTH+3:TAG_WIDTH+2];
    assign nt_tag = exc_rd[2*TAG_WIDTH+3:TAG_WIDTH+4];

    assign bias      = choice_rd[1];
    assign t_hit     = (t_tag == tag);
    assign nt_hit    = (nt_tag == tag);
    assign is_update = (mode == yags_pkg::MODE_UPDATE);

    always_comb
    begin
        ctl.choice_we = item_valid && is_update;
        ctl.exc_we    = item_valid && is_update;
        ctl.push      = item_valid && !is_update;
        if (bias)
        begin
            ctl.pred = t_hit ? t_ctr[1] : 1'b1;
        end
        else
        begin
            ctl.pred = nt_hit ? nt_ctr[1] : 1'b0;
        end
    end

    always_comb
    begin
        choice_wd = yags_pkg::sat_step(choice_rd, taken);
        t_tag_wd  = t_tag;
        t_ctr_wd  = t_ctr;
        nt_tag_wd = nt_tag;
        nt_ctr_wd = nt_ctr;
        if (bias)
        begin
            if (t_hit)
            begin
                t_ctr_wd = yags_pkg::sat_step(t_ctr, taken);
            end
            else if (!taken)
            begin
                t_tag_wd = tag;
                t_ctr_wd = yags_pkg::CTR_WEAK_NT;
            end
        end
        else
        begin
            if (nt_hit)
            begin
                nt_ctr_wd = yags_pkg::sat_step(nt_ctr, taken);
            end
            else if (taken)
            begin
                nt_tag_wd = tag;
                nt_ctr_wd = yags_pkg::CTR_WEAK_T;
            end
        end
        exc_wd = {nt_tag_wd, nt_ctr_wd, t_tag_wd, t_ctr_wd};
    end

endmodule

[design/yags_out_fifo.sv]
// small result buffer between the update stage and the output channel
module yags_out_fifo (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    input  logic                           push_data,
    input  logic                           pop,
    output logic                           not_empty,
    output logic                           head_data,
    output logic [yags_pkg::OUT_CNT_BITS-1:0] count
);

    logic [yags_pkg::OUT_DEPTH-1:0]        data_reg;
    logic [yags_pkg::OUT_PTR_BITS-1:0]     wptr_reg;
    logic [yags_pkg::OUT_PTR_BITS-1:0]     wptr_next;
    logic [yags_pkg::OUT_PTR_BITS-1:0]     rptr_reg;
    logic [yags_pkg::OUT_PTR_BITS-1:0]     rptr_next;
    logic [yags_pkg::OUT_CNT_BITS-1:0]     cnt_reg;
    logic [yags_pkg::OUT_CNT_BITS-1:0]     cnt_next;
    logic                                  do_pop;

    localparam logic [yags_pkg::OUT_PTR_BITS-1:0] LAST_PTR =
        yags_pkg::OUT_PTR_BITS'(yags_pkg::OUT_DEPTH - 1);

    assign not_empty = (cnt_reg != '0);
    assign head_data = data_reg[rptr_reg];
    assign count     = cnt_reg;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (push)
        begin
            wptr_next = (wptr_reg == LAST_PTR) ? '0 : wptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rptr_next = (rptr_reg == LAST_PTR) ? '0 : rptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!push && do_pop)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg[wptr_reg] <= push_data;
        end
    end

endmodule

[design/yags_branch_predictor_core.sv]
// yags branch predictor top level: choice table, exception caches, result buffer
// result path: a predict word is registered in the lookup stage while the tables are
//   read, then its result is written into the result buffer, which drives m_tdata
// throughput: one word per cycle, predicts and updates mixed freely, as long as
//   results drain; a read-modify-write of one table entry per word sets this rate
// reset: after rst_n the tables are swept to their reset values, one entry a cycle,
//   over 2**max(CHOICE_INDEX_BITS, EXCEPTION_INDEX_BITS) sweep addresses (4096 by default);
//   s_tready stays low during the sweep
module yags_branch_predictor_core #(
    parameter int CHOICE_INDEX_BITS    = yags_pkg::CHOICE_INDEX_BITS_DEF,
    parameter int EXCEPTION_INDEX_BITS = yags_pkg::EXCEPTION_INDEX_BITS_DEF,
    parameter int TAG_WIDTH            = yags_pkg::TAG_WIDTH_DEF,
    parameter int PC_SHIFT             = yags_pkg::PC_SHIFT_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // branch_addr [63:0], global_history [73:64], outcome_taken [74], zero [79:75]
    input  logic [yags_pkg::IN_DATA_BITS-1:0]  s_tdata,
    // mode [0]
    input  logic                               s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // predict_taken [0], zero [7:1]
    output logic [yags_pkg::OUT_DATA_BITS-1:0] m_tdata
);

    localparam int CI        = CHOICE_INDEX_BITS;
    localparam int EI        = EXCEPTION_INDEX_BITS;
    localparam int MAXB      = (CI > EI) ? CI : EI;
    localparam int EXC_BITS  = 2 * TAG_WIDTH + 4;
    localparam int PC_BITS   = yags_pkg::PC_BITS;
    localparam int HIST_BITS = yags_pkg::HIST_BITS;

    // exception word after reset: both tags zero, taken counter strong taken,
    // not-taken counter strong not-taken
    localparam logic [EXC_BITS-1:0] EXC_RESET_WORD =
        {{TAG_WIDTH{1'b0}}, yags_pkg::CTR_STRONG_NT, {TAG_WIDTH{1'b0}}, yags_pkg::CTR_STRONG_T};

    // ---------------------------------------------------------------
    // input word fields and hashes
    // ---------------------------------------------------------------
    logic [PC_BITS-1:0]        in_pc;
    logic [HIST_BITS-1:0]      in_hist;
    logic                      in_taken;
    logic [PC_BITS-1:0]        in_shifted;
    logic [EI+HIST_BITS-1:0]   in_hist_ext;
    logic [CI-1:0]             in_ci;
    logic [EI-1:0]             in_ei;
    logic [TAG_WIDTH-1:0]      in_tag;
    logic                      in_accept;

    assign in_pc       = s_tdata[PC_BITS-1:0];
    assign in_hist     = s_tdata[PC_BITS+HIST_BITS-1:PC_BITS];
    assign in_taken    = s_tdata[PC_BITS+HIST_BITS];
    assign in_shifted  = in_pc >> PC_SHIFT;
    // history wider than the index drops its upper bits, narrower gets zeros
    assign in_hist_ext = {{EI{1'b0}}, in_hist};
    assign in_ci       = in_shifted[CI-1:0];
    assign in_ei       = in_shifted[EI-1:0] ^ in_hist_ext[EI-1:0];
    assign in_tag      = in_shifted[TAG_WIDTH-1:0];
    assign in_accept   = s_tvalid && s_tready;

    // ---------------------------------------------------------------
    // reset sweep over both tables
    // ---------------------------------------------------------------
    logic [MAXB:0] clr_cnt_reg;
    logic [MAXB:0] clr_cnt_next;
    logic          clr_done;

    assign clr_done     = clr_cnt_reg[MAXB];
    assign clr_cnt_next = clr_done ? clr_cnt_reg : clr_cnt_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else
        begin
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    // ---------------------------------------------------------------
    // lookup stage: word waits here while the tables are read
    // ---------------------------------------------------------------
    logic                 s1_valid_reg;
    logic                 s1_mode_reg;
    logic                 s1_taken_reg;
    logic [TAG_WIDTH-1:0] s1_tag_reg;
    logic [CI-1:0]        s1_ci_reg;
    logic [EI-1:0]        s1_ei_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_mode_reg  <= s_tuser;
            s1_taken_reg <= in_taken;
            s1_tag_reg   <= in_tag;
            s1_ci_reg    <= in_ci;
            s1_ei_reg    <= in_ei;
        end
    end

    // ---------------------------------------------------------------
    // tables
    // ---------------------------------------------------------------
    yags_pkg::ctr_t       choice_rd;
    yags_pkg::ctr_t       choice_wd;
    logic [EXC_BITS-1:0]  exc_rd;
    logic [EXC_BITS-1:0]  exc_wd;
    yags_pkg::yags_ctl_t  ctl;

    logic                 choice_we;
    logic [CI-1:0]        choice_waddr;
    yags_pkg::ctr_t       choice_wdata;
    logic                 exc_we;
    logic [EI-1:0]        exc_waddr;
    logic [EXC_BITS-1:0]  exc_wdata;

    // the sweep owns the write ports until done, then the update stage does
    always_comb
    begin
        if (!clr_done)
        begin
            choice_we    = 1'b1;
            choice_waddr = clr_cnt_reg[CI-1:0];
            choice_wdata = yags_pkg::CTR_WEAK_NT;
            exc_we       = 1'b1;
            exc_waddr    = clr_cnt_reg[EI-1:0];
            exc_wdata    = EXC_RESET_WORD;
        end
        else
        begin
            choice_we    = ctl.choice_we;
            choice_waddr = s1_ci_reg;
            choice_wdata = choice_wd;
            exc_we       = ctl.exc_we;
            exc_waddr    = s1_ei_reg;
            exc_wdata    = exc_wd;
        end
    end

    yags_ram #(
        .ADDR_BITS (CI),
        .DATA_BITS (2)
    ) u_choice_ram (
        .clk   (clk),
        .we    (choice_we),
        .waddr (choice_waddr),
        .wdata (choice_wdata),
        .raddr (in_ci),
        .rdata (choice_rd)
    );

    yags_ram #(
        .ADDR_BITS (EI),
        .DATA_BITS (EXC_BITS)
    ) u_exc_ram (
        .clk   (clk),
        .we    (exc_we),
        .waddr (exc_waddr),
        .wdata (exc_wdata),
        .raddr (in_ei),
        .rdata (exc_rd)
    );

    // ---------------------------------------------------------------
    // forwarding: the word in the update stage was read in the same cycle
    // that the word ahead of it wrote, so the ram gave it stale data
    // ---------------------------------------------------------------
    logic                 fwd_c_valid_reg;
    logic [CI-1:0]        fwd_c_addr_reg;
    yags_pkg::ctr_t       fwd_c_data_reg;
    logic                 fwd_e_valid_reg;
    logic [EI-1:0]        fwd_e_addr_reg;
    logic [EXC_BITS-1:0]  fwd_e_data_reg;
    yags_pkg::ctr_t       choice_cur;
    logic [EXC_BITS-1:0]  exc_cur;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_c_valid_reg <= 1'b0;
            fwd_e_valid_reg <= 1'b0;
        end
        else
        begin
            fwd_c_valid_reg <= clr_done && ctl.choice_we;
            fwd_e_valid_reg <= clr_done && ctl.exc_we;
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_c_addr_reg <= s1_ci_reg;
        fwd_c_data_reg <= choice_wd;
        fwd_e_addr_reg <= s1_ei_reg;
        fwd_e_data_reg <= exc_wd;
    end

    assign choice_cur = (fwd_c_valid_reg && (fwd_c_addr_reg == s1_ci_reg))
                        ? fwd_c_data_reg : choice_rd;
    assign exc_cur    = (fwd_e_valid_reg && (fwd_e_addr_reg == s1_ei_reg))
                        ? fwd_e_data_reg : exc_rd;

    // ---------------------------------------------------------------
    // predict / update
    // ---------------------------------------------------------------
    yags_calc #(
        .TAG_WIDTH (TAG_WIDTH)
    ) u_calc (
        .item_valid (s1_valid_reg),
        .mode       (s1_mode_reg),
        .taken      (s1_taken_reg),
        .tag        (s1_tag_reg),
        .choice_rd  (choice_cur),
        .exc_rd     (exc_cur),
        .choice_wd  (choice_wd),
        .exc_wd     (exc_wd),
        .ctl        (ctl)
    );

    // ---------------------------------------------------------------
    // result buffer and input flow control
    // ---------------------------------------------------------------
    logic [yags_pkg::OUT_CNT_BITS-1:0] fifo_cnt;
    logic [yags_pkg::OUT_CNT_BITS:0]   in_flight;
    logic                              out_bit;

    yags_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (ctl.push),
        .push_data (ctl.pred),
        .pop       (m_tready),
        .not_empty (m_tvalid),
        .head_data (out_bit),
        .count     (fifo_cnt)
    );

    // a word in the update stage always has a buffer slot reserved
    assign in_flight = {1'b0, fifo_cnt} + {{yags_pkg::OUT_CNT_BITS{1'b0}}, s1_valid_reg};
    assign s_tready  = clr_done &&
                       (in_flight < (yags_pkg::OUT_CNT_BITS + 1)'(yags_pkg::OUT_DEPTH));
    assign m_tdata   = {{(yags_pkg::OUT_DATA_BITS-1){1'b0}}, out_bit};

endmodule

[test/yags_direction_checker.sv]
// checker for the yags core: mirrors its tables and compares predicted directions
`timescale 1ns / 100ps
module yags_direction_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    input  logic                               s_tready,
    // branch_addr [63:0], global_history [73:64], outcome_taken [74], zero [79:75]
    input  logic [yags_pkg::IN_DATA_BITS-1:0]  s_tdata,
    // mode [0]
    input  logic                               s_tuser,
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    // predict_taken [0], zero [7:1]
    input  logic [yags_pkg::OUT_DATA_BITS-1:0] m_tdata,
    output int unsigned                        mismatches,
    output int unsigned                        awaited
);

    localparam int PC_W      = yags_pkg::PC_BITS;
    localparam int HIST_W    = yags_pkg::HIST_BITS;
    localparam int CI_W      = yags_pkg::CHOICE_INDEX_BITS_DEF;
    localparam int EI_W      = yags_pkg::EXCEPTION_INDEX_BITS_DEF;
    localparam int TAG_W     = yags_pkg::TAG_WIDTH_DEF;
    localparam int HIST_LSB  = PC_W;
    localparam int TAKEN_BIT = PC_W + HIST_W;

    yags_pkg::ctr_t   choice_ctr [1 << CI_W];
    logic [TAG_W-1:0] tk_tag     [1 << EI_W];
    yags_pkg::ctr_t   tk_ctr     [1 << EI_W];
    logic [TAG_W-1:0] nt_tag     [1 << EI_W];
    yags_pkg::ctr_t   nt_ctr     [1 << EI_W];

    // directions still owed by the core, oldest first
    logic             dir_queue [$];

    function automatic yags_pkg::ctr_t nudge(input yags_pkg::ctr_t c, input logic up);
        if (up)
        begin
            return (c == yags_pkg::CTR_STRONG_T) ? c : yags_pkg::ctr_t'(c + 2'd1);
        end
        return (c == yags_pkg::CTR_STRONG_NT) ? c : yags_pkg::ctr_t'(c - 2'd1);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : mirror
        logic [PC_W-1:0]  shifted;
        logic [CI_W-1:0]  ci;
        logic [EI_W-1:0]  ei;
        logic [TAG_W-1:0] tg;
        logic             taken;
        logic             bias_t;
        logic             dir;
        logic             want;
        if (!rst_n)
        begin
            foreach (choice_ctr[i])
            begin
                choice_ctr[i] = yags_pkg::CTR_WEAK_NT;
            end
            foreach (tk_tag[i])
            begin
                tk_tag[i] = '0;
                tk_ctr[i] = yags_pkg::CTR_STRONG_T;
                nt_tag[i] = '0;
                nt_ctr[i] = yags_pkg::CTR_STRONG_NT;
            end
            dir_queue.delete();
            mismatches = 0;
            awaited    = 0;
        end
        else
        begin
            // a result at this edge always belongs to an earlier word
            if (m_tvalid && m_tready)
            begin
                if (dir_queue.size() == 0)
                begin
                    if (mismatches < 10)
                    begin
                        $display("unexpected result: predict_taken %0b with none awaited at %0t",
                                 m_tdata[0], $time);
                    end
                    mismatches++;
                end
                else
                begin
                    want = dir_queue.pop_front();
                    if (m_tdata[0] !== want)
                    begin
                        if (mismatches < 10)
                        begin
                            $display("predict_taken mismatch: expected %0b, got %0b at %0t",
                                     want, m_tdata[0], $time);
                        end
                        mismatches++;
                    end
                end
            end

            if (s_tvalid && s_tready)
            begin
                shifted = s_tdata[PC_W-1:0] >> yags_pkg::PC_SHIFT_DEF;
                ci      = shifted[CI_W-1:0];
                ei      = EI_W'(shifted ^ PC_W'(s_tdata[HIST_LSB +: HIST_W]));
                tg      = shifted[TAG_W-1:0];
                taken   = s_tdata[TAKEN_BIT];
                bias_t  = (choice_ctr[ci] >= yags_pkg::CTR_WEAK_T);

                if (s_tuser == yags_pkg::MODE_PREDICT)
                begin
                    dir = bias_t;
                    if (bias_t && tk_tag[ei] == tg)
                    begin
                        dir = (tk_ctr[ei] >= yags_pkg::CTR_WEAK_T);
                    end
                    else if (!bias_t && nt_tag[ei] == tg)
                    begin
                        dir = (nt_ctr[ei] >= yags_pkg::CTR_WEAK_T);
                    end
                    dir_queue.push_back(dir);
                end
                else
                begin
                    choice_ctr[ci] = nudge(choice_ctr[ci], taken);
                    if (bias_t)
                    begin
                        if (tk_tag[ei] == tg)
                        begin
                            tk_ctr[ei] = nudge(tk_ctr[ei], taken);
                        end
                        else if (!taken)
                        begin
                            tk_tag[ei] = tg;
                            tk_ctr[ei] = yags_pkg::CTR_WEAK_NT;
                        end
                    end
                    else
                    begin
                        if (nt_tag[ei] == tg)
                        begin
                            nt_ctr[ei] = nudge(nt_ctr[ei], taken);
                        end
                        else if (taken)
                        begin
                            nt_tag[ei] = tg;
                            nt_ctr[ei] = yags_pkg::CTR_WEAK_T;
                        end
                    end
                end
            end
            awaited = dir_queue.size();
        end
    end

endmodule

[test/tb.sv]
// testbench top: drives predict and update words into the yags core and gives the verdict
`timescale 1ns / 100ps
module tb;

    // generous bound: reset sweep plus ~1200 words with gaps and stalls
    localparam int CYCLE_LIMIT  = 500000;
    localparam int PHASE_WORDS  = 300;
    localparam int POOL_SIZE    = 24;

    // traffic phases: no idling, sender gaps, receiver stalls, both
    localparam int SEND_IDLE  [4] = '{0, 62, 0, 9};
    localparam int SINK_STALL [4] = '{0, 0, 62, 9};

    logic                               clk      = 1'b0;
    logic                               rst_n    = 1'b0;
    logic                               s_tvalid = 1'b0;
    logic                               s_tready;
    // branch_addr [63:0], global_history [73:64], outcome_taken [74], zero [79:75]
    logic [yags_pkg::IN_DATA_BITS-1:0]  s_tdata  = '0;
    // mode [0]
    logic                               s_tuser  = yags_pkg::MODE_PREDICT;
    logic                               m_tvalid;
    logic                               m_tready = 1'b0;
    // predict_taken [0], zero [7:1]
    logic [yags_pkg::OUT_DATA_BITS-1:0] m_tdata;

    int unsigned mismatches;
    int unsigned awaited;
    int unsigned send_idle_pct  = 0;
    int unsigned sink_stall_pct = 0;
    int unsigned cycles         = 0;

    // small pool of branches so updates keep hitting the same table entries
    logic [63:0] pc_pool   [POOL_SIZE];
    logic        pool_bias [POOL_SIZE];
    logic [9:0]  hist_pool [4];

    // 12 ns period
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    yags_branch_predictor_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    yags_direction_checker watch (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .mismatches (mismatches),
        .awaited    (awaited)
    );

    // receiver side: stalls at the rate of the current phase
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // offer one word, returning at the edge where it was taken;
    // s_tready is read at the falling edge, when everything has settled
    task automatic send_word(input logic mode, input logic [63:0] pc,
                             input logic [9:0] hist, input logic taken);
        logic took;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {5'b0, taken, hist, pc};
        took = 1'b0;
        while (!took)
        begin
            @(negedge clk);
            took = s_tready;
            @(posedge clk);
        end
    endtask

    // hold off the sender until every owed direction has come back
    task automatic wait_drained;
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (awaited != 0)
        begin
            @(negedge clk);
        end
        @(posedge clk);
    endtask

    initial
    begin : stimulus
        logic [63:0] pc;
        logic [63:0] br_a;
        logic [9:0]  hist;
        logic        taken;
        logic        mode;
        int          idx;

        // reset held low, then released; the core then sweeps its tables with s_tready low
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // --- directed part ---
        br_a = 64'h0000_0000_0000_0124;
        // zero tag hits the reset not-taken entry, which agrees with its bias
        send_word(yags_pkg::MODE_PREDICT, 64'h0, 10'h0, 1'b0);
        // all ones in every field, outcome ignored on a predict
        send_word(yags_pkg::MODE_PREDICT, 64'hFFFF_FFFF_FFFF_FFFF, 10'h3FF, 1'b1);
        // zero tag again, now through an update that steps the reset entries
        send_word(yags_pkg::MODE_UPDATE, 64'h1000, 10'h0, 1'b1);
        send_word(yags_pkg::MODE_PREDICT, 64'h1000, 10'h0, 1'b0);
        send_word(yags_pkg::MODE_UPDATE, 64'h1000, 10'h0, 1'b0);
        // not-taken bias, taken outcome: allocate in the not-taken cache, then saturate the choice counter
        repeat (3) send_word(yags_pkg::MODE_UPDATE, br_a, 10'h155, 1'b1);
        send_word(yags_pkg::MODE_PREDICT, br_a, 10'h155, 1'b0);
        // taken bias, not-taken outcome under other history: taken cache allocation
        send_word(yags_pkg::MODE_UPDATE, br_a, 10'h2AA, 1'b0);
        send_word(yags_pkg::MODE_PREDICT, br_a, 10'h2AA, 1'b0);
        send_word(yags_pkg::MODE_PREDICT, br_a, 10'h155, 1'b1);
        // walk the choice and not-taken counters back down to strongly not-taken
        repeat (4) send_word(yags_pkg::MODE_UPDATE, br_a, 10'h155, 1'b0);
        send_word(yags_pkg::MODE_PREDICT, br_a, 10'h155, 1'b0);
        // top of the address range
        send_word(yags_pkg::MODE_UPDATE, 64'hFFFF_FFFF_FFFF_FFFC, 10'h3FF, 1'b1);
        send_word(yags_pkg::MODE_PREDICT, 64'hFFFF_FFFF_FFFF_FFFC, 10'h3FF, 1'b0);
        // low address bits below the shift are dropped
        send_word(yags_pkg::MODE_PREDICT, 64'h8000_0000_0000_0007, 10'h200, 1'b0);

        // sender pauses until every owed direction has come back
        wait_drained();

        // --- random part, one phase per traffic pattern ---
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct  <= SEND_IDLE[ph];
            sink_stall_pct <= SINK_STALL[ph];

            // fresh pool: low address bits crowded so index and tag collisions happen
            for (int i = 0; i < POOL_SIZE; i++)
            begin
                pc_pool[i]       = {$urandom, $urandom};
                pc_pool[i][13:2] = 12'($urandom_range(47));
                pool_bias[i]     = 1'($urandom);
            end
            for (int j = 0; j < 3; j++)
            begin
                hist_pool[j] = 10'($urandom_range(31));
            end
            hist_pool[3] = 10'($urandom);

            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                if ($urandom_range(99) < 80)
                begin
                    // mostly pool branches with a mostly steady direction
                    idx   = $urandom_range(POOL_SIZE - 1);
                    pc    = pc_pool[idx];
                    hist  = hist_pool[$urandom_range(3)];
                    taken = pool_bias[idx] ^ ($urandom_range(3) == 0);
                end
                else
                begin
                    pc    = {$urandom, $urandom};
                    hist  = 10'($urandom);
                    taken = 1'($urandom);
                end
                mode = $urandom_range(1) ? yags_pkg::MODE_UPDATE : yags_pkg::MODE_PREDICT;
                send_word(mode, pc, hist, taken);
            end
            wait_drained();
        end

        // wait on past the core's result path so late extras get caught
        repeat (8) @(posedge clk);
        @(negedge clk);
        if (mismatches == 0 && awaited == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
